// ----- hw/rtl/limit_order_book_tracker_assert.svh -----
// assertion macros for the limit order book tracker
// used by the controller; relies on clk and arst_n in the including module
`ifndef LIMIT_ORDER_BOOK_TRACKER_ASSERT_SVH
`define LIMIT_ORDER_BOOK_TRACKER_ASSERT_SVH
`ifndef SYNTHESIS
`define LOBT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define LOBT_ASSERT_NEXT(lbl, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) else $error(msg);
`else
`define LOBT_ASSERT(lbl, prop, msg)
`define LOBT_ASSERT_NEXT(lbl, a, b, msg)
`endif
`endif

// ----- hw/rtl/lobt_pkg.sv -----
// shared constants, codes and control types of the order book tracker
// no dependencies
package lobt_pkg;
	localparam int ORDER_SLOTS  = 1024;
	localparam int PRICE_LEVELS = 256;
	localparam int OIDX_W = $clog2(ORDER_SLOTS);
	localparam int LIDX_W = $clog2(PRICE_LEVELS);

	// update types
	localparam logic [2:0] CMD_INVALID    = 3'd0;
	localparam logic [2:0] CMD_ADD        = 3'd1;
	localparam logic [2:0] CMD_MODIFY     = 3'd2;
	localparam logic [2:0] CMD_CANCEL     = 3'd3;
	localparam logic [2:0] CMD_TRADE      = 3'd4;
	localparam logic [2:0] CMD_CLEAR      = 3'd5;
	localparam logic [2:0] CMD_SNAP_START = 3'd6;
	localparam logic [2:0] CMD_SNAP_END   = 3'd7;

	// status codes
	localparam logic [2:0] ST_APPLIED = 3'd0;
	localparam logic [2:0] ST_RANGE   = 3'd1;
	localparam logic [2:0] ST_ALIAS   = 3'd2;
	localparam logic [2:0] ST_INVALID = 3'd3;
	localparam logic [2:0] ST_DUP     = 3'd4;

	typedef enum logic [4:0] {
		OP_NONE, OP_LATCH, OP_STATUS, OP_ORD_RD, OP_ADD_APP, OP_TAIL1, OP_TAIL2,
		OP_INS_START, OP_INS_STEP, OP_LNK1, OP_LNK2, OP_MOD, OP_CAN_A, OP_CAN_B,
		OP_CLEAR, OP_SWEEP, OP_REF_SIDE, OP_REF_LV, OP_REF_SUM
	} op_t;

	typedef struct packed {
		op_t        op;
		logic       sel;
		logic [2:0] st;
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic       in_range;
		logic       dup;
		logic       alias_hit;
		logic       lv_fresh;
		logic       ring_empty;
		logic       ins_stop;
		logic       live;
		logic       sweep_last;
		logic       hv_sel;
		logic       sum_last;
	} dp_stat_t;
endpackage

// ----- hw/rtl/lobt_dp.sv -----
// datapath: order and level memories, ring heads, walk registers, held top of book
// depends on lobt_pkg
module lobt_dp import lobt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_stat_t           stat,
	input  logic [2:0]         command,
	input  logic [31:0]        ord_id,
	input  logic               side,
	input  logic [31:0]        price,
	input  logic [31:0]        qty,
	output logic [2:0]         status,
	output logic               bid_valid,
	output logic [31:0]        bid_price,
	output logic [31:0]        bid_qty,
	output logic               ask_valid,
	output logic [31:0]        ask_price,
	output logic [31:0]        ask_qty
);
	// latched transaction
	logic [2:0]        cmd_q;
	logic              in_range_q;
	logic [OIDX_W-1:0] id_q;
	logic              side_q;
	logic [31:0]       price_q;
	logic [31:0]       qty_q;
	logic [LIDX_W-1:0] lv_q;
	logic [2:0]        status_q;

	// walk registers
	logic [LIDX_W-1:0] t_q;
	logic              wend_q;
	logic              found_q;
	logic [OIDX_W-1:0] first_q;
	logic [OIDX_W-1:0] p_q;
	logic [OIDX_W-1:0] n_q;
	logic [31:0]       sum_q;
	logic [OIDX_W-1:0] cnt_q;

	// book control state
	logic [PRICE_LEVELS-1:0] llive_q;
	logic                    bid_hv_q, ask_hv_q;
	logic [LIDX_W-1:0]       bid_head_q, ask_head_q;
	logic [31:0]             held_bp_q, held_bq_q, held_ap_q, held_aq_q;

	// order memories
	logic              ol_mem [ORDER_SLOTS];
	logic [31:0]       oprice_mem [ORDER_SLOTS];
	logic [31:0]       oqty_mem [ORDER_SLOTS];
	logic [OIDX_W-1:0] onext_mem [ORDER_SLOTS];
	logic [OIDX_W-1:0] oprev_mem [ORDER_SLOTS];
	logic              ol_rd;
	logic [31:0]       oprice_rd, oqty_rd;
	logic [OIDX_W-1:0] onext_rd, oprev_rd;

	// level memories
	logic              lside_mem [PRICE_LEVELS];
	logic [31:0]       lprice_mem [PRICE_LEVELS];
	logic [OIDX_W-1:0] lfirst_mem [PRICE_LEVELS];
	logic [LIDX_W-1:0] lnext_mem [PRICE_LEVELS];
	logic [LIDX_W-1:0] lprev_mem [PRICE_LEVELS];
	logic              lside_rd;
	logic [31:0]       lprice_rd;
	logic [OIDX_W-1:0] lfirst_rd;
	logic [LIDX_W-1:0] lnext_rd, lprev_rd;

	// port controls
	logic              o_re, l_re;
	logic [OIDX_W-1:0] o_ra;
	logic [LIDX_W-1:0] l_ra;
	logic              ol_we, op_we, oq_we, on_we, ov_we;
	logic [OIDX_W-1:0] ol_wa, op_wa, oq_wa, on_wa, ov_wa;
	logic              ol_wd;
	logic [31:0]       oq_wd;
	logic [OIDX_W-1:0] on_wd, ov_wd;
	logic              lnew_we, lf_we, ln_we, lv_we;
	logic [LIDX_W-1:0] lf_wa, ln_wa, lv_wa;
	logic [OIDX_W-1:0] lf_wd;
	logic [LIDX_W-1:0] ln_wd, lv_wd;

	logic              less_aggr;
	logic [LIDX_W-1:0] sel_head, side_head;
	logic              side_hv;
	logic              cb_single, cb_remove;

	assign sel_head  = cmd.sel ? ask_head_q : bid_head_q;
	assign side_head = side_q ? ask_head_q : bid_head_q;
	assign side_hv   = side_q ? ask_hv_q : bid_hv_q;
	assign less_aggr = side_q ? (price_q > lprice_rd) : (price_q < lprice_rd);
	assign cb_single = (p_q == id_q);
	assign cb_remove = cb_single && llive_q[lv_q];

	// status back to the controller
	always_comb begin
		stat.cmd        = cmd_q;
		stat.in_range   = in_range_q;
		stat.dup        = ol_rd;
		stat.alias_hit  = llive_q[lv_q] && (lprice_rd != price_q);
		stat.lv_fresh   = !llive_q[lv_q];
		stat.ring_empty = !side_hv;
		stat.ins_stop   = wend_q || !less_aggr;
		stat.live       = ol_rd;
		stat.sweep_last = (cnt_q == OIDX_W'(ORDER_SLOTS - 1));
		stat.hv_sel     = cmd.sel ? ask_hv_q : bid_hv_q;
		stat.sum_last   = (onext_rd == first_q);
	end

	// read addresses
	always_comb begin
		o_re = 1'b0;
		o_ra = id_q;
		l_re = 1'b0;
		l_ra = lv_q;
		unique case (cmd.op)
			OP_ORD_RD: begin
				o_re = 1'b1;
				l_re = 1'b1;
			end
			OP_ADD_APP: begin
				o_re = llive_q[lv_q];
				o_ra = lfirst_rd;
			end
			OP_INS_START: begin
				l_re = side_hv;
				l_ra = side_head;
			end
			OP_INS_STEP: begin
				l_re = !(wend_q || !less_aggr);
				l_ra = lnext_rd;
			end
			OP_CAN_A: begin
				l_re = ol_rd;
				l_ra = oprice_rd[LIDX_W-1:0];
			end
			OP_REF_SIDE: begin
				l_re = 1'b1;
				l_ra = sel_head;
			end
			OP_REF_LV: begin
				o_re = 1'b1;
				o_ra = lfirst_rd;
			end
			OP_REF_SUM: begin
				o_re = 1'b1;
				o_ra = onext_rd;
			end
			default: ;
		endcase
	end

	// order memory writes
	always_comb begin
		ol_we = 1'b0; ol_wa = id_q; ol_wd = 1'b0;
		op_we = 1'b0; op_wa = id_q;
		oq_we = 1'b0; oq_wa = id_q; oq_wd = qty_q;
		on_we = 1'b0; on_wa = id_q; on_wd = id_q;
		ov_we = 1'b0; ov_wa = id_q; ov_wd = id_q;
		unique case (cmd.op)
			OP_ADD_APP: begin
				ol_we = 1'b1;
				ol_wd = 1'b1;
				op_we = 1'b1;
				oq_we = 1'b1;
				on_we = !llive_q[lv_q];
				ov_we = !llive_q[lv_q];
			end
			OP_TAIL1: begin
				on_we = 1'b1; on_wa = oprev_rd; on_wd = id_q;
				ov_we = 1'b1; ov_wa = id_q; ov_wd = oprev_rd;
			end
			OP_TAIL2: begin
				on_we = 1'b1; on_wa = id_q; on_wd = first_q;
				ov_we = 1'b1; ov_wa = first_q; ov_wd = id_q;
			end
			OP_MOD: oq_we = ol_rd;
			OP_CAN_A: ol_we = ol_rd;
			OP_CAN_B: begin
				on_we = !cb_single; on_wa = p_q; on_wd = n_q;
				ov_we = !cb_single; ov_wa = n_q; ov_wd = p_q;
			end
			OP_SWEEP: begin
				ol_we = 1'b1;
				ol_wa = cnt_q;
			end
			default: ;
		endcase
	end

	// level memory writes
	always_comb begin
		lnew_we = (cmd.op == OP_ADD_APP) && !llive_q[lv_q];
		lf_we = lnew_we; lf_wa = lv_q; lf_wd = id_q;
		ln_we = 1'b0; ln_wa = lv_q; ln_wd = lv_q;
		lv_we = 1'b0; lv_wa = lv_q; lv_wd = lv_q;
		unique case (cmd.op)
			OP_INS_START: begin
				ln_we = !side_hv;
				lv_we = !side_hv;
			end
			OP_LNK1: begin
				ln_we = 1'b1; ln_wa = lprev_rd; ln_wd = lv_q;
				lv_we = 1'b1; lv_wa = lv_q; lv_wd = lprev_rd;
			end
			OP_LNK2: begin
				ln_we = 1'b1; ln_wa = lv_q; ln_wd = t_q;
				lv_we = 1'b1; lv_wa = t_q; lv_wd = lv_q;
			end
			OP_CAN_B: begin
				lf_we = !cb_single && llive_q[lv_q] && (lfirst_rd == id_q);
				lf_wd = n_q;
				ln_we = cb_remove && (lnext_rd != lv_q);
				ln_wa = lprev_rd; ln_wd = lnext_rd;
				lv_we = cb_remove && (lnext_rd != lv_q);
				lv_wa = lnext_rd; lv_wd = lprev_rd;
			end
			default: ;
		endcase
	end

	// order memories
	always_ff @(posedge clk) begin
		if (ol_we) ol_mem[ol_wa] <= ol_wd;
		if (op_we) oprice_mem[op_wa] <= price_q;
		if (oq_we) oqty_mem[oq_wa] <= oq_wd;
		if (on_we) onext_mem[on_wa] <= on_wd;
		if (ov_we) oprev_mem[ov_wa] <= ov_wd;
		if (o_re) begin
			ol_rd     <= ol_mem[o_ra];
			oprice_rd <= oprice_mem[o_ra];
			oqty_rd   <= oqty_mem[o_ra];
			onext_rd  <= onext_mem[o_ra];
			oprev_rd  <= oprev_mem[o_ra];
		end
	end

	// level memories
	always_ff @(posedge clk) begin
		if (lnew_we) begin
			lside_mem[lv_q]  <= side_q;
			lprice_mem[lv_q] <= price_q;
		end
		if (lf_we) lfirst_mem[lf_wa] <= lf_wd;
		if (ln_we) lnext_mem[ln_wa] <= ln_wd;
		if (lv_we) lprev_mem[lv_wa] <= lv_wd;
		if (l_re) begin
			lside_rd  <= lside_mem[l_ra];
			lprice_rd <= lprice_mem[l_ra];
			lfirst_rd <= lfirst_mem[l_ra];
			lnext_rd  <= lnext_mem[l_ra];
			lprev_rd  <= lprev_mem[l_ra];
		end
	end

	// transaction and walk payload registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LATCH: begin
				cmd_q      <= command;
				in_range_q <= (ord_id < 32'(ORDER_SLOTS));
				id_q       <= ord_id[OIDX_W-1:0];
				side_q     <= side;
				price_q    <= price;
				qty_q      <= qty;
				lv_q       <= price[LIDX_W-1:0];
			end
			OP_ADD_APP: first_q <= lfirst_rd;
			OP_INS_START: begin
				t_q    <= side_head;
				wend_q <= 1'b0;
			end
			OP_INS_STEP: begin
				if (wend_q || !less_aggr) begin
					found_q <= !wend_q;
				end else begin
					t_q    <= lnext_rd;
					wend_q <= (lnext_rd == side_head);
				end
			end
			OP_CAN_A: begin
				lv_q <= oprice_rd[LIDX_W-1:0];
				p_q  <= oprev_rd;
				n_q  <= onext_rd;
			end
			OP_REF_LV: begin
				first_q <= lfirst_rd;
				sum_q   <= '0;
			end
			OP_REF_SUM: sum_q <= sum_q + oqty_rd;
			default: ;
		endcase
	end

	// book control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q   <= ST_APPLIED;
			cnt_q      <= '0;
			llive_q    <= '0;
			bid_hv_q   <= 1'b0;
			ask_hv_q   <= 1'b0;
			bid_head_q <= '0;
			ask_head_q <= '0;
			held_bp_q  <= '0;
			held_bq_q  <= '0;
			held_ap_q  <= '0;
			held_aq_q  <= '0;
		end else begin
			unique case (cmd.op)
				OP_LATCH: status_q <= ST_APPLIED;
				OP_STATUS: status_q <= cmd.st;
				OP_ADD_APP: if (!llive_q[lv_q]) llive_q[lv_q] <= 1'b1;
				OP_INS_START: begin
					if (!side_hv) begin
						if (side_q) begin
							ask_hv_q <= 1'b1; ask_head_q <= lv_q;
						end else begin
							bid_hv_q <= 1'b1; bid_head_q <= lv_q;
						end
					end
				end
				OP_LNK2: begin
					if (found_q && (t_q == side_head)) begin
						if (side_q) ask_head_q <= lv_q;
						else bid_head_q <= lv_q;
					end
				end
				OP_CAN_B: begin
					if (cb_remove) begin
						llive_q[lv_q] <= 1'b0;
						if (lnext_rd == lv_q) begin
							if (lside_rd) ask_hv_q <= 1'b0;
							else bid_hv_q <= 1'b0;
						end else if (lside_rd) begin
							if (ask_head_q == lv_q) ask_head_q <= lnext_rd;
						end else begin
							if (bid_head_q == lv_q) bid_head_q <= lnext_rd;
						end
					end
				end
				OP_CLEAR: begin
					llive_q    <= '0;
					bid_hv_q   <= 1'b0;
					ask_hv_q   <= 1'b0;
					bid_head_q <= '0;
					ask_head_q <= '0;
					cnt_q      <= '0;
				end
				OP_SWEEP: cnt_q <= cnt_q + 1'b1;
				OP_REF_SIDE: begin
					if (!(cmd.sel ? ask_hv_q : bid_hv_q)) begin
						if (cmd.sel) begin
							held_ap_q <= '0; held_aq_q <= '0;
						end else begin
							held_bp_q <= '0; held_bq_q <= '0;
						end
					end
				end
				OP_REF_LV: begin
					if (cmd.sel) held_ap_q <= lprice_rd;
					else held_bp_q <= lprice_rd;
				end
				OP_REF_SUM: begin
					if (onext_rd == first_q) begin
						if (cmd.sel) held_aq_q <= sum_q + oqty_rd;
						else held_bq_q <= sum_q + oqty_rd;
					end
				end
				default: ;
			endcase
		end
	end

	assign status    = status_q;
	assign bid_valid = bid_hv_q;
	assign bid_price = held_bp_q;
	assign bid_qty   = held_bq_q;
	assign ask_valid = ask_hv_q;
	assign ask_price = held_ap_q;
	assign ask_qty   = held_aq_q;
endmodule

// ----- hw/rtl/lobt_ctrl.sv -----
// controller: sequences each update through the datapath micro-operations
// depends on lobt_pkg and limit_order_book_tracker_assert.svh
`include "limit_order_book_tracker_assert.svh"
module lobt_ctrl import lobt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	output logic     done,
	output dp_cmd_t  cmd,
	input  dp_stat_t stat
);
	localparam logic [4:0] S_INIT     = 5'd0;
	localparam logic [4:0] S_IDLE     = 5'd1;
	localparam logic [4:0] S_DISP     = 5'd2;
	localparam logic [4:0] S_ADD_CHK  = 5'd3;
	localparam logic [4:0] S_TAIL1    = 5'd4;
	localparam logic [4:0] S_TAIL2    = 5'd5;
	localparam logic [4:0] S_INS      = 5'd6;
	localparam logic [4:0] S_INS_STEP = 5'd7;
	localparam logic [4:0] S_LNK1     = 5'd8;
	localparam logic [4:0] S_LNK2     = 5'd9;
	localparam logic [4:0] S_MOD      = 5'd10;
	localparam logic [4:0] S_CAN_A    = 5'd11;
	localparam logic [4:0] S_CAN_B    = 5'd12;
	localparam logic [4:0] S_SWEEP    = 5'd13;
	localparam logic [4:0] S_REF_SIDE = 5'd14;
	localparam logic [4:0] S_REF_LV   = 5'd15;
	localparam logic [4:0] S_REF_SUM  = 5'd16;
	localparam logic [4:0] S_DONE     = 5'd17;

	logic [4:0] state_q, state_d;
	logic       sel_q, sel_d;

	// next state and micro-operation
	always_comb begin
		state_d = state_q;
		sel_d   = sel_q;
		cmd.op  = OP_NONE;
		cmd.sel = sel_q;
		cmd.st  = ST_APPLIED;
		unique case (state_q)
			S_INIT: begin
				cmd.op = OP_SWEEP;
				if (stat.sweep_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.op  = OP_LATCH;
					sel_d   = 1'b0;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				unique case (stat.cmd)
					CMD_INVALID: begin
						cmd.op = OP_STATUS; cmd.st = ST_INVALID; state_d = S_DONE;
					end
					CMD_ADD, CMD_MODIFY, CMD_CANCEL: begin
						if (!stat.in_range) begin
							cmd.op = OP_STATUS; cmd.st = ST_RANGE; state_d = S_DONE;
						end else begin
							cmd.op = OP_ORD_RD;
							if (stat.cmd == CMD_ADD) state_d = S_ADD_CHK;
							else if (stat.cmd == CMD_MODIFY) state_d = S_MOD;
							else state_d = S_CAN_A;
						end
					end
					CMD_CLEAR, CMD_SNAP_START: begin
						cmd.op = OP_CLEAR; state_d = S_SWEEP;
					end
					default: state_d = S_REF_SIDE;
				endcase
			end
			S_ADD_CHK: begin
				if (stat.dup) begin
					cmd.op = OP_STATUS; cmd.st = ST_DUP; state_d = S_DONE;
				end else if (stat.alias_hit) begin
					cmd.op = OP_STATUS; cmd.st = ST_ALIAS; state_d = S_DONE;
				end else begin
					cmd.op  = OP_ADD_APP;
					state_d = stat.lv_fresh ? S_INS : S_TAIL1;
				end
			end
			S_TAIL1: begin
				cmd.op = OP_TAIL1; state_d = S_TAIL2;
			end
			S_TAIL2: begin
				cmd.op = OP_TAIL2; state_d = S_REF_SIDE;
			end
			S_INS: begin
				cmd.op  = OP_INS_START;
				state_d = stat.ring_empty ? S_REF_SIDE : S_INS_STEP;
			end
			S_INS_STEP: begin
				cmd.op = OP_INS_STEP;
				if (stat.ins_stop) state_d = S_LNK1;
			end
			S_LNK1: begin
				cmd.op = OP_LNK1; state_d = S_LNK2;
			end
			S_LNK2: begin
				cmd.op = OP_LNK2; state_d = S_REF_SIDE;
			end
			S_MOD: begin
				cmd.op = OP_MOD; state_d = S_REF_SIDE;
			end
			S_CAN_A: begin
				cmd.op  = OP_CAN_A;
				state_d = stat.live ? S_CAN_B : S_REF_SIDE;
			end
			S_CAN_B: begin
				cmd.op = OP_CAN_B; state_d = S_REF_SIDE;
			end
			S_SWEEP: begin
				cmd.op = OP_SWEEP;
				if (stat.sweep_last) state_d = S_REF_SIDE;
			end
			S_REF_SIDE: begin
				cmd.op = OP_REF_SIDE;
				if (stat.hv_sel) state_d = S_REF_LV;
				else if (sel_q) state_d = S_DONE;
				else sel_d = 1'b1;
			end
			S_REF_LV: begin
				cmd.op = OP_REF_LV; state_d = S_REF_SUM;
			end
			S_REF_SUM: begin
				cmd.op = OP_REF_SUM;
				if (stat.sum_last) begin
					if (sel_q) begin
						state_d = S_DONE;
					end else begin
						sel_d   = 1'b1;
						state_d = S_REF_SIDE;
					end
				end
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			sel_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

	// sequencing checks
	`LOBT_ASSERT_NEXT(a_start_busy, start && !busy, busy && !done, "accepted transaction not held busy")
	`LOBT_ASSERT_NEXT(a_done_pulse, done, !done && !busy, "result strobe longer than one cycle")
	`LOBT_ASSERT(a_done_busy, done |-> busy, "result strobe outside busy")
endmodule

// ----- hw/rtl/limit_order_book_tracker.sv -----
// limit order book tracker top level: one result per update, strobed on done for one cycle
// sequence, accept to strobe: invalid, out-of-range and dropped add updates set status and strobe;
// else the update, if any (a walk of levels on a sorted insert, a sweep of the order live table for
// clear), then a refresh of each side, summing the resting orders of its best level if live, then strobe
// throughput: one update at a time, next update accepted in the cycle after the strobe; receiver cannot stall
// reset: busy held high during a clearing pass of the order live table
module limit_order_book_tracker import lobt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  command,
	input  logic [31:0] ord_id,
	input  logic        side,
	input  logic [31:0] price,
	input  logic [31:0] qty,
	output logic        done,
	output logic [2:0]  status,
	output logic        bid_valid,
	output logic [31:0] bid_price,
	output logic [31:0] bid_qty,
	output logic        ask_valid,
	output logic [31:0] ask_price,
	output logic [31:0] ask_qty
);
	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencer
	lobt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.cmd(cmd), .stat(stat)
	);

	// book datapath
	lobt_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.command(command), .ord_id(ord_id), .side(side), .price(price), .qty(qty),
		.status(status), .bid_valid(bid_valid), .bid_price(bid_price), .bid_qty(bid_qty),
		.ask_valid(ask_valid), .ask_price(ask_price), .ask_qty(ask_qty)
	);
endmodule
